// ----- src/pta_pkg.sv -----
// Shared types and constants of the pan/tilt servo aiming block.
package pta_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_APPLY,
    ST_CMUL,
    ST_CDIV,
    ST_DONE
  } state_e;

  // Input mode codes; code three is a no-op
  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_CENTER = 2'd1,
    MODE_TRACK  = 2'd2
  } mode_e;

  // Register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_TRACK_GAIN  = 3'd2;
  localparam logic [2:0] REG_JOY_GAIN    = 3'd3;
  localparam logic [2:0] REG_DEAD_ZONE   = 3'd4;
  localparam logic [2:0] REG_COMPARE_MIN = 3'd5;
  localparam logic [2:0] REG_COMPARE_MAX = 3'd6;

  // Field widths
  localparam int POS_W  = 10;
  localparam int GAIN_W = 16;
  localparam int CMP_W  = 16;
  localparam int GAIN_FRAC = 12;
  localparam int STEP_PROD_W = POS_W + GAIN_W;

  // Digit counts of the serial units (two bits per multiply digit)
  localparam int STEP_DIGITS = POS_W / 2;
  localparam int CMP_DIGITS  = CMP_W / 2;
  localparam int QUOT_BITS   = CMP_W;

  // Register reset values
  localparam logic [POS_W-1:0]  CENTER_X_RST    = 10'd160;
  localparam logic [POS_W-1:0]  CENTER_Y_RST    = 10'd120;
  localparam logic [GAIN_W-1:0] TRACK_GAIN_RST  = 16'd2048;
  localparam logic [GAIN_W-1:0] JOY_GAIN_RST    = 16'd205;
  localparam logic [POS_W-1:0]  DEAD_ZONE_RST   = 10'd15;
  localparam logic [CMP_W-1:0]  COMPARE_MIN_RST = 16'd500;
  localparam logic [CMP_W-1:0]  COMPARE_MAX_RST = 16'd2500;

endpackage

// ----- src/pan_tilt_servo_aim_top.sv -----
// Pan/tilt servo aiming: mode and coordinate in, two servo compare counts out.
// Sequence per input transaction: a radix-4 step multiply, an angle update, a radix-4
//   compare multiply and a restoring divide by 180 degrees; the step multiply and angle
//   update are skipped when no angle step is taken (center, manual-mode dead zone or
//   no-op). A new input is taken only after the result is loaded into the output register.
// Reset: default registers, both angles at 90 degrees, no result pending.
module pan_tilt_servo_aim_top #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  pos_x_i,
  input  logic [9:0]  pos_y_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pan_compare_o,
  output logic [15:0] tilt_compare_o,
  output logic        updated_o
);

  localparam int AW    = 8 + ANGLE_FRAC_BITS;
  localparam int SH_L  = (ANGLE_FRAC_BITS >= pta_pkg::GAIN_FRAC) ?
                         ANGLE_FRAC_BITS - pta_pkg::GAIN_FRAC : 0;
  localparam int SH_R  = (ANGLE_FRAC_BITS >= pta_pkg::GAIN_FRAC) ?
                         0 : pta_pkg::GAIN_FRAC - ANGLE_FRAC_BITS;
  localparam int STW   = pta_pkg::STEP_PROD_W + SH_L;
  localparam int SUMW  = STW + 2;
  localparam int PW    = AW + pta_pkg::CMP_W;
  localparam logic [AW-1:0] DEG90  = AW'(90) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] DEG180 = AW'(180) << ANGLE_FRAC_BITS;
  localparam logic [PW-1:0] DIV_INIT = PW'(180) << (ANGLE_FRAC_BITS + pta_pkg::QUOT_BITS - 1);

  // Configuration registers
  logic [9:0]  center_x_q, center_y_q, dead_zone_q;
  logic [15:0] track_gain_q, joy_gain_q, compare_min_q, compare_max_q;

  // Angle state
  logic [AW-1:0] pan_angle_q, tilt_angle_q;

  // Sequencer
  pta_pkg::state_e state_q, state_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            in_accept, start_cmp, out_load;

  // Per-item working registers
  logic        track_q, upd_q, sgn_x_q, sgn_y_q;
  logic [15:0] gain_q;
  logic [9:0]  magx_sr_q, magy_sr_q;
  logic [pta_pkg::STEP_PROD_W-1:0] accx_q, accy_q;
  logic [15:0] span_sr_q;
  logic [PW-1:0] rem_p_q, rem_t_q, dsh_q;
  logic [15:0] quot_p_q, quot_t_q;

  // Output register
  logic        out_valid_q, out_upd_q;
  logic [15:0] out_pan_q, out_tilt_q;

  // Input decode
  logic signed [10:0] off_x, off_y;
  logic [9:0]  abs_x, abs_y;
  logic        in_dz, go_step, set_center, upd_in;

  assign off_x = $signed({1'b0, pos_x_i}) - $signed({1'b0, center_x_q});
  assign off_y = $signed({1'b0, pos_y_i}) - $signed({1'b0, center_y_q});
  assign abs_x = off_x[10] ? 10'(-off_x) : off_x[9:0];
  assign abs_y = off_y[10] ? 10'(-off_y) : off_y[9:0];
  assign in_dz = (abs_x < dead_zone_q) && (abs_y < dead_zone_q);

  always_comb begin
    go_step    = 1'b0;
    set_center = 1'b0;
    upd_in     = 1'b0;
    unique case (pta_pkg::mode_e'(mode_i))
      pta_pkg::MODE_MANUAL: begin
        go_step = !in_dz;
        upd_in  = !in_dz;
      end
      pta_pkg::MODE_CENTER: begin
        set_center = 1'b1;
        upd_in     = 1'b1;
      end
      pta_pkg::MODE_TRACK: begin
        go_step = 1'b1;
        upd_in  = 1'b1;
      end
      default: ;
    endcase
  end

  // Compare span, zero when the range is inverted
  logic [15:0] span;
  assign span = (compare_max_q >= compare_min_q) ? compare_max_q - compare_min_q : '0;

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    start_cmp  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      pta_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (go_step) begin
            state_d = pta_pkg::ST_STEP;
          end else begin
            state_d   = pta_pkg::ST_CMUL;
            start_cmp = 1'b1;
          end
        end
      end
      pta_pkg::ST_STEP: begin
        if (cnt_q == 4'(pta_pkg::STEP_DIGITS - 1)) state_d = pta_pkg::ST_APPLY;
      end
      pta_pkg::ST_APPLY: begin
        state_d   = pta_pkg::ST_CMUL;
        start_cmp = 1'b1;
      end
      pta_pkg::ST_CMUL: begin
        if (cnt_q == 4'(pta_pkg::CMP_DIGITS - 1)) state_d = pta_pkg::ST_CDIV;
      end
      pta_pkg::ST_CDIV: begin
        if (cnt_q == 4'(pta_pkg::QUOT_BITS - 1)) state_d = pta_pkg::ST_DONE;
      end
      pta_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pta_pkg::ST_IDLE;
        end
      end
      default: state_d = pta_pkg::ST_IDLE;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign cnt_d     = (state_d != state_q) ? '0 : cnt_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pta_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= pta_pkg::CENTER_X_RST;
      center_y_q    <= pta_pkg::CENTER_Y_RST;
      track_gain_q  <= pta_pkg::TRACK_GAIN_RST;
      joy_gain_q    <= pta_pkg::JOY_GAIN_RST;
      dead_zone_q   <= pta_pkg::DEAD_ZONE_RST;
      compare_min_q <= pta_pkg::COMPARE_MIN_RST;
      compare_max_q <= pta_pkg::COMPARE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pta_pkg::REG_CENTER_X:    center_x_q    <= cfg_data_i[9:0];
        pta_pkg::REG_CENTER_Y:    center_y_q    <= cfg_data_i[9:0];
        pta_pkg::REG_TRACK_GAIN:  track_gain_q  <= cfg_data_i;
        pta_pkg::REG_JOY_GAIN:    joy_gain_q    <= cfg_data_i;
        pta_pkg::REG_DEAD_ZONE:   dead_zone_q   <= cfg_data_i[9:0];
        pta_pkg::REG_COMPARE_MIN: compare_min_q <= cfg_data_i;
        pta_pkg::REG_COMPARE_MAX: compare_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Angle update: rescale step, add to base, saturate to 0..180 degrees
  logic [STW-1:0]         step_x, step_y;
  logic [AW-1:0]          base_p, base_t, pan_sat, tilt_sat;
  logic signed [SUMW-1:0] pan_sum, tilt_sum;

  assign step_x = (STW'(accx_q) << SH_L) >> SH_R;
  assign step_y = (STW'(accy_q) << SH_L) >> SH_R;
  assign base_p = track_q ? DEG90 : pan_angle_q;
  assign base_t = track_q ? DEG90 : tilt_angle_q;

  // pan moves against x offset, tilt with y offset
  assign pan_sum  = sgn_x_q ? $signed(SUMW'(base_p)) + $signed(SUMW'(step_x))
                            : $signed(SUMW'(base_p)) - $signed(SUMW'(step_x));
  assign tilt_sum = sgn_y_q ? $signed(SUMW'(base_t)) - $signed(SUMW'(step_y))
                            : $signed(SUMW'(base_t)) + $signed(SUMW'(step_y));

  always_comb begin
    if (pan_sum[SUMW-1])                       pan_sat = '0;
    else if ($unsigned(pan_sum) > SUMW'(DEG180)) pan_sat = DEG180;
    else                                       pan_sat = pan_sum[AW-1:0];
    if (tilt_sum[SUMW-1])                       tilt_sat = '0;
    else if ($unsigned(tilt_sum) > SUMW'(DEG180)) tilt_sat = DEG180;
    else                                        tilt_sat = tilt_sum[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_angle_q  <= DEG90;
      tilt_angle_q <= DEG90;
    end else if (in_accept && set_center) begin
      pan_angle_q  <= DEG90;
      tilt_angle_q <= DEG90;
    end else if (state_q == pta_pkg::ST_APPLY) begin
      pan_angle_q  <= pan_sat;
      tilt_angle_q <= tilt_sat;
    end
  end

  // Serial datapath: radix-4 multiplies MSB first, then restoring divide
  logic [pta_pkg::STEP_PROD_W-1:0] gain_x2;
  logic [PW-1:0] pan_ext, tilt_ext;
  logic          ge_p, ge_t;

  assign gain_x2  = pta_pkg::STEP_PROD_W'(gain_q) << 1;
  assign pan_ext  = PW'(pan_angle_q);
  assign tilt_ext = PW'(tilt_angle_q);
  assign ge_p     = rem_p_q >= dsh_q;
  assign ge_t     = rem_t_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      track_q   <= (mode_i == pta_pkg::MODE_TRACK);
      upd_q     <= upd_in;
      sgn_x_q   <= off_x[10];
      sgn_y_q   <= off_y[10];
      magx_sr_q <= abs_x;
      magy_sr_q <= abs_y;
      gain_q    <= (mode_i == pta_pkg::MODE_TRACK) ? track_gain_q : joy_gain_q;
      accx_q    <= '0;
      accy_q    <= '0;
    end else if (state_q == pta_pkg::ST_STEP) begin
      accx_q <= (accx_q << 2) + (magx_sr_q[9] ? gain_x2 : '0)
              + (magx_sr_q[8] ? pta_pkg::STEP_PROD_W'(gain_q) : '0);
      accy_q <= (accy_q << 2) + (magy_sr_q[9] ? gain_x2 : '0)
              + (magy_sr_q[8] ? pta_pkg::STEP_PROD_W'(gain_q) : '0);
      magx_sr_q <= magx_sr_q << 2;
      magy_sr_q <= magy_sr_q << 2;
    end

    if (start_cmp) begin
      span_sr_q <= span;
      rem_p_q   <= '0;
      rem_t_q   <= '0;
      dsh_q     <= DIV_INIT;
    end else if (state_q == pta_pkg::ST_CMUL) begin
      rem_p_q <= (rem_p_q << 2) + (span_sr_q[15] ? pan_ext << 1 : '0)
               + (span_sr_q[14] ? pan_ext : '0);
      rem_t_q <= (rem_t_q << 2) + (span_sr_q[15] ? tilt_ext << 1 : '0)
               + (span_sr_q[14] ? tilt_ext : '0);
      span_sr_q <= span_sr_q << 2;
    end else if (state_q == pta_pkg::ST_CDIV) begin
      rem_p_q  <= ge_p ? rem_p_q - dsh_q : rem_p_q;
      rem_t_q  <= ge_t ? rem_t_q - dsh_q : rem_t_q;
      quot_p_q <= {quot_p_q[14:0], ge_p};
      quot_t_q <= {quot_t_q[14:0], ge_t};
      dsh_q    <= dsh_q >> 1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pan_q  <= compare_min_q + quot_p_q;
      out_tilt_q <= compare_min_q + quot_t_q;
      out_upd_q  <= upd_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pan_compare_o  = out_pan_q;
  assign tilt_compare_o = out_tilt_q;
  assign updated_o      = out_upd_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pta_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pan_angle_q <= DEG180) && (tilt_angle_q <= DEG180))
    else $error("angle outside 0..180 degrees");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pta_pkg::ST_DONE) |-> (quot_p_q <= span) && (quot_t_q <= span))
    else $error("compare offset exceeds span");

endmodule
